### rtl/css_pkg.sv
// shared constants and register map for the clocked step sequencer
package css_pkg;

  localparam int NUM_STEPS    = 8;
  localparam int GATE_SAMPLES = 48;

  localparam int STEP_W   = $clog2(NUM_STEPS);
  localparam int GATE_W   = 16;
  localparam int LEVEL_W  = 8;
  localparam int CLK_W    = 12;
  localparam int OFS_W    = 5;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 6;
  localparam int REG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_STEP_LEVELS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FORWARD     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_BASE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_BASE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_BASE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIVIDE_BASE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CLK_HIGH    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLK_LOW     = 3'd7;

  localparam logic signed [CLK_W-1:0] CLK_HIGH_RESET = 12'sd409;
  localparam logic signed [CLK_W-1:0] CLK_LOW_RESET  = 12'sd20;

endpackage

### rtl/clocked_step_sequencer.sv
// clocked step sequencer with schmitt-trigger clock input and clock divider
//
// Input channel (in_*): one audio-rate sample per transfer, a signed 12-bit
// clock code plus four signed 5-bit offsets for start, end, stride and division.
// Result channel (out_*): exactly one result per input sample, in order: held
// step level, gate, current step index and an advanced flag.
// Configuration: APB-style port, 64-bit data, register i at byte address 8*i;
// pready is always high and reads return the register value. The user must write
// registers only while no sample is in flight; the block does not enforce it.
// Throughput: one sample per clock while the receiver does not stall; the input
// register and the result register each hold one sample, and the state update
// sits between them.
// When the receiver stalls, the result register holds its contents, the input
// register fills, and then in_stall rises until the result is taken.
// Reset (rst_n low at a clock edge) empties both registers, loads the register
// defaults and puts the sequencer at step 0, trigger high, gate idle.
module clocked_step_sequencer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [css_pkg::CLK_W-1:0]      in_clock_sample,
  input  logic signed [css_pkg::OFS_W-1:0]      in_start_offset,
  input  logic signed [css_pkg::OFS_W-1:0]      in_end_offset,
  input  logic signed [css_pkg::OFS_W-1:0]      in_stride_offset,
  input  logic signed [css_pkg::OFS_W-1:0]      in_divide_offset,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [css_pkg::LEVEL_W-1:0]           out_level_out,
  output logic                                  out_gate_out,
  output logic [2:0]                            out_step_index,
  output logic                                  out_advanced,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [css_pkg::ADDR_W-1:0]            paddr,
  input  logic [css_pkg::DATA_W-1:0]            pwdata,
  output logic [css_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  localparam int SW = css_pkg::STEP_W;
  localparam logic signed [6:0] TOP_S = 7'(css_pkg::NUM_STEPS - 1);
  localparam logic [SW-1:0] TOP_U = SW'(css_pkg::NUM_STEPS - 1);

  // configuration registers
  logic [css_pkg::DATA_W-1:0]       step_levels_r;
  logic                             forward_r;
  logic [2:0]                       start_base_r;
  logic [2:0]                       end_base_r;
  logic [2:0]                       stride_base_r;
  logic [3:0]                       divide_base_r;
  logic signed [css_pkg::CLK_W-1:0] clk_high_r;
  logic signed [css_pkg::CLK_W-1:0] clk_low_r;

  logic                             cfg_wr;
  logic [css_pkg::REG_IDX_W-1:0]    cfg_idx;

  // input register
  logic                             s1_valid_r;
  logic signed [css_pkg::CLK_W-1:0] s1_clock_r;
  logic signed [css_pkg::OFS_W-1:0] s1_start_ofs_r;
  logic signed [css_pkg::OFS_W-1:0] s1_end_ofs_r;
  logic signed [css_pkg::OFS_W-1:0] s1_stride_ofs_r;
  logic signed [css_pkg::OFS_W-1:0] s1_divide_ofs_r;

  // sequencer state
  logic [SW-1:0]                    position_r;
  logic [2:0]                       divide_count_r;
  logic                             trigger_high_r;
  logic [css_pkg::GATE_W-1:0]       gate_count_r;
  logic [css_pkg::LEVEL_W-1:0]      held_level_r;

  // result register
  logic                             out_valid_r;
  logic [css_pkg::LEVEL_W-1:0]      out_level_r;
  logic                             out_gate_r;
  logic [2:0]                       out_step_r;
  logic                             out_adv_r;

  logic                             in_load;
  logic                             out_free;
  logic                             s1_fire;

  // next-state values
  logic [SW-1:0]                    position_nxt;
  logic [2:0]                       divide_count_nxt;
  logic                             trigger_high_nxt;
  logic [css_pkg::GATE_W-1:0]       gate_count_nxt;
  logic [css_pkg::LEVEL_W-1:0]      held_level_nxt;
  logic                             gate_nxt;
  logic                             adv_nxt;

  logic                             clk_edge;
  logic signed [6:0]                div_sum;
  logic signed [6:0]                st_sum;
  logic signed [6:0]                en_sum;
  logic signed [6:0]                sd_sum;
  logic [3:0]                       div_lim;
  logic [SW-1:0]                    st_pos;
  logic [SW-1:0]                    en_pos;
  logic [SW-1:0]                    sd_val;
  logic [3:0]                       cnt_inc;
  logic                             cnt_wrap;
  logic [SW:0]                      fwd_sum;
  logic [SW:0]                      bwd_diff;
  logic [SW-1:0]                    step_pos;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_load  = in_valid && !in_stall;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[css_pkg::ADDR_W-1:3];

  always_comb begin
    case (cfg_idx)
      css_pkg::REG_STEP_LEVELS: prdata = step_levels_r;
      css_pkg::REG_FORWARD:     prdata = 64'(forward_r);
      css_pkg::REG_START_BASE:  prdata = 64'(start_base_r);
      css_pkg::REG_END_BASE:    prdata = 64'(end_base_r);
      css_pkg::REG_STRIDE_BASE: prdata = 64'(stride_base_r);
      css_pkg::REG_DIVIDE_BASE: prdata = 64'(divide_base_r);
      css_pkg::REG_CLK_HIGH:    prdata = 64'($unsigned(clk_high_r));
      css_pkg::REG_CLK_LOW:     prdata = 64'($unsigned(clk_low_r));
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_levels_r <= '0;
      forward_r     <= 1'b1;
      start_base_r  <= 3'd7;
      end_base_r    <= 3'd7;
      stride_base_r <= 3'd1;
      divide_base_r <= 4'd1;
      clk_high_r    <= css_pkg::CLK_HIGH_RESET;
      clk_low_r     <= css_pkg::CLK_LOW_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        css_pkg::REG_STEP_LEVELS: step_levels_r <= pwdata;
        css_pkg::REG_FORWARD:     forward_r     <= pwdata[0];
        css_pkg::REG_START_BASE:  start_base_r  <= pwdata[2:0];
        css_pkg::REG_END_BASE:    end_base_r    <= pwdata[2:0];
        css_pkg::REG_STRIDE_BASE: stride_base_r <= pwdata[2:0];
        css_pkg::REG_DIVIDE_BASE: divide_base_r <= pwdata[3:0];
        css_pkg::REG_CLK_HIGH:    clk_high_r    <= $signed(pwdata[css_pkg::CLK_W-1:0]);
        css_pkg::REG_CLK_LOW:     clk_low_r     <= $signed(pwdata[css_pkg::CLK_W-1:0]);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_clock_r      <= in_clock_sample;
      s1_start_ofs_r  <= in_start_offset;
      s1_end_ofs_r    <= in_end_offset;
      s1_stride_ofs_r <= in_stride_offset;
      s1_divide_ofs_r <= in_divide_offset;
    end
  end

  // per-sample step logic
  always_comb begin
    trigger_high_nxt = trigger_high_r;
    clk_edge         = 1'b0;
    if (trigger_high_r) begin
      if (s1_clock_r <= clk_low_r) trigger_high_nxt = 1'b0;
    end else if (s1_clock_r >= clk_high_r) begin
      trigger_high_nxt = 1'b1;
      clk_edge         = 1'b1;
    end

    // clamped controls
    div_sum = $signed({3'b000, divide_base_r}) + 7'(s1_divide_ofs_r);
    st_sum  = $signed({4'b0000, start_base_r}) + 7'(s1_start_ofs_r);
    en_sum  = $signed({4'b0000, end_base_r}) + 7'(s1_end_ofs_r);
    sd_sum  = $signed({4'b0000, stride_base_r}) + 7'(s1_stride_ofs_r);

    if (div_sum < 7'sd1)      div_lim = 4'd1;
    else if (div_sum > 7'sd8) div_lim = 4'd8;
    else                      div_lim = div_sum[3:0];

    if (st_sum < 7'sd0)       st_pos = '0;
    else if (st_sum > TOP_S)  st_pos = TOP_U;
    else                      st_pos = st_sum[SW-1:0];

    if (en_sum < 7'sd0)       en_pos = '0;
    else if (en_sum > TOP_S)  en_pos = TOP_U;
    else                      en_pos = en_sum[SW-1:0];

    if (sd_sum < 7'sd1)       sd_val = SW'(1);
    else if (sd_sum > TOP_S)  sd_val = TOP_U;
    else                      sd_val = sd_sum[SW-1:0];

    // clock divider
    cnt_inc  = {1'b0, divide_count_r} + 4'd1;
    cnt_wrap = cnt_inc >= div_lim;
    divide_count_nxt = divide_count_r;
    if (clk_edge) divide_count_nxt = cnt_wrap ? 3'd0 : cnt_inc[2:0];
    adv_nxt = clk_edge && cnt_wrap;

    // step movement
    fwd_sum  = {1'b0, position_r} + {1'b0, sd_val};
    bwd_diff = {1'b0, position_r} - {1'b0, sd_val};
    if (forward_r) begin
      if (position_r == en_pos)   step_pos = st_pos;
      else if (fwd_sum > {1'b0, TOP_U}) step_pos = '0;
      else                        step_pos = fwd_sum[SW-1:0];
    end else begin
      if (position_r == st_pos)   step_pos = en_pos;
      else if (bwd_diff[SW])      step_pos = TOP_U;
      else                        step_pos = bwd_diff[SW-1:0];
    end

    position_nxt   = adv_nxt ? step_pos : position_r;
    held_level_nxt = held_level_r;
    if (adv_nxt) begin
      if (32'(step_pos) < 32'd8) held_level_nxt = step_levels_r[8*step_pos +: 8];
      else                       held_level_nxt = '0;
    end

    // gate pulse
    gate_nxt = gate_count_r != '0;
    if (adv_nxt)       gate_count_nxt = css_pkg::GATE_W'(css_pkg::GATE_SAMPLES);
    else if (gate_nxt) gate_count_nxt = gate_count_r - css_pkg::GATE_W'(1);
    else               gate_count_nxt = gate_count_r;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= '0;
      divide_count_r <= '0;
      trigger_high_r <= 1'b1;
      gate_count_r   <= '0;
      held_level_r   <= '0;
    end else if (s1_fire) begin
      position_r     <= position_nxt;
      divide_count_r <= divide_count_nxt;
      trigger_high_r <= trigger_high_nxt;
      gate_count_r   <= gate_count_nxt;
      held_level_r   <= held_level_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_level_r <= held_level_nxt;
      out_gate_r  <= gate_nxt;
      out_step_r  <= 3'(position_nxt);
      out_adv_r   <= adv_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level_out  = out_level_r;
  assign out_gate_out   = out_gate_r;
  assign out_step_index = out_step_r;
  assign out_advanced   = out_adv_r;

  // a step taken always reloads the gate counter
  a_gate_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && adv_nxt) |=> (gate_count_r == css_pkg::GATE_W'(css_pkg::GATE_SAMPLES)))
    else $error("gate counter not reloaded on step");

  // a pending advanced result implies the trigger is still high
  a_adv_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_adv_r) |-> trigger_high_r)
    else $error("advanced result without high trigger");

  // the input side only stalls while the input register holds a sample
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room to accept");

  // held level and output level agree after every sample taken from the input register
  a_level_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_level_r == held_level_r))
    else $error("result level differs from held level");

endmodule
